>>> hw/rtl/assert_macros.svh
// assertion macros shared by the rtl files
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication checked on the next clock edge
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/hpe_pkg.sv
// package for the histogram palette extractor: constants and payload types
// no dependencies
package hpe_pkg;

  localparam int unsigned BinsPerChannel = 16;
  localparam int unsigned ChanBinBits    = $clog2(BinsPerChannel);
  localparam int unsigned BinIdxBits     = 3 * ChanBinBits;
  localparam int unsigned NumBins        = BinsPerChannel * BinsPerChannel * BinsPerChannel;
  localparam int unsigned CountBits      = 24;
  localparam int unsigned MaxPalette     = 64;
  localparam int unsigned RankIdxBits    = (MaxPalette > 1) ? $clog2(MaxPalette) : 1;
  localparam int unsigned RankCntBits    = $clog2(MaxPalette + 1);
  localparam int unsigned MeanBits       = 24;
  localparam int unsigned RankBits       = BinIdxBits + CountBits;
  localparam int unsigned PaletteBits    = 7;
  localparam logic [PaletteBits-1:0] PaletteReset = 7'd16;
  localparam int unsigned AddrBits       = 1;

  // register word addresses (paddr bits above the byte offset)
  localparam logic [AddrBits-1:0] RegPaletteCount = 1'b0;

  typedef struct packed {
    logic [7:0] pixel_red;
    logic [7:0] pixel_green;
    logic [7:0] pixel_blue;
    logic       last_pixel;
  } pixel_t;

  typedef struct packed {
    logic [7:0] color_red;
    logic [7:0] color_green;
    logic [7:0] color_blue;
    logic       last_color;
  } color_t;

  // bin of one channel: (x * bins) >> 8
  function automatic logic [ChanBinBits-1:0] chan_bin(logic [7:0] x);
    logic [8+ChanBinBits-1:0] p;
    p = {{ChanBinBits{1'b0}}, x} * (8+ChanBinBits)'(BinsPerChannel);
    return p[8+ChanBinBits-1:8];
  endfunction

endpackage

>>> hw/rtl/hpe_ram.sv
// generic single port ram, registered read
// no dependencies
module hpe_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

>>> hw/rtl/histogram_palette_extractor_top.sv
// Histogram palette extractor. A pixel transaction on the input channel
// (valid_i / stall_o) is binned by the top bits of each channel into one of
// 4096 bins, each holding a count and a truncating running mean per channel.
// An update reads the bin memories, divides by count+1 with one shared
// restoring divider (a load step, 8 steps and a drain step per channel,
// 3 channels) and writes back; no new pixel is taken until it is written.
// On a pixel with last_pixel set the block then ranks the bins: each palette
// entry is one full scan of 4096 bins (one bin per cycle, then a pipeline
// tail) and a pick step, with one extra scan when the used bins run out
// before palette_count.
// Each color is read from the rank and bin memories into an output register,
// presented on the output channel (valid_o / stall_i) and held while stall_i
// is high. A final clearing pass over all 4096 bins zeroes them; the same
// pass runs after reset, during which stall_o is high. Configuration writes
// over APB are taken at any time; palette_count is read when ranking starts.
`include "assert_macros.svh"
module histogram_palette_extractor_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                stall_o,
  input  hpe_pkg::pixel_t     pixel_i,
  output logic                valid_o,
  input  logic                stall_i,
  output hpe_pkg::color_t     color_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [hpe_pkg::AddrBits+1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  localparam int unsigned IB = hpe_pkg::BinIdxBits;
  localparam int unsigned CB = hpe_pkg::CountBits;
  localparam int unsigned RB = hpe_pkg::RankIdxBits;
  localparam int unsigned NB = hpe_pkg::RankCntBits;
  localparam logic [CB-1:0] CountMax = {CB{1'b1}};

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_RD, S_DIV, S_WR, S_SCAN, S_PICK, S_ORD, S_ORDW,
    S_EMIT, S_OUT
  } state_e;

  state_e state_q;
  logic [hpe_pkg::PaletteBits-1:0] pal_q;
  hpe_pkg::pixel_t px_q;
  logic [IB-1:0] bin_q, addr;
  logic [IB:0]   scan_q;          // scan counter, one extra bit for the pipeline tail
  logic          scan_vld_q;
  logic [IB-1:0] scan_idx_q;
  logic [CB-1:0] cnt_q;           // count of the bin being updated
  logic [23:0]   mean_q;
  logic [1:0]    ch_q;
  logic [3:0]    step_q;
  logic [CB+8:0] rem_q;
  logic [CB+8:0] quo_q;
  logic [CB+8:0] num_w;
  logic [7:0]    mean_ch, px_ch;
  logic          best_fnd_q;
  logic [CB-1:0] best_cnt_q, prev_cnt_q;
  logic [IB-1:0] best_idx_q, prev_idx_q;
  logic [NB-1:0] k_q, n_q, lim_q;
  hpe_pkg::color_t out_q;
  logic          out_vld_q;

  // memories
  logic          m_we, c_we, r_we;
  logic [23:0]   m_wd, m_rd;
  logic [CB-1:0] c_wd, c_rd;
  logic [RB-1:0] r_addr;
  logic [hpe_pkg::RankBits-1:0] r_wd, r_rd;

  hpe_ram #(.Width(24), .Depth(hpe_pkg::NumBins)) u_means (
    .clk_i, .we_i(m_we), .addr_i(addr), .wdata_i(m_wd), .rdata_o(m_rd));
  hpe_ram #(.Width(CB), .Depth(hpe_pkg::NumBins)) u_counts (
    .clk_i, .we_i(c_we), .addr_i(addr), .wdata_i(c_wd), .rdata_o(c_rd));
  hpe_ram #(.Width(hpe_pkg::RankBits), .Depth(hpe_pkg::MaxPalette)) u_rank (
    .clk_i, .we_i(r_we), .addr_i(r_addr), .wdata_i(r_wd), .rdata_o(r_rd));

  // apb
  assign pready = 1'b1;
  always_comb begin
    prdata = '0;
    if (paddr[hpe_pkg::AddrBits+1:2] == hpe_pkg::RegPaletteCount) begin
      prdata = 32'(pal_q);
    end
  end

  always_comb begin
    unique case (ch_q)
      2'd0:    begin mean_ch = mean_q[23:16]; px_ch = px_q.pixel_red;   end
      2'd1:    begin mean_ch = mean_q[15:8];  px_ch = px_q.pixel_green; end
      default: begin mean_ch = mean_q[7:0];   px_ch = px_q.pixel_blue;  end
    endcase
  end

  logic [CB+8:0] den;
  logic [CB+8:0] rem_sh, rem_sub;
  assign den     = (CB+9)'(cnt_q) + (CB+9)'(1);
  // shift in quotient-register bits msb first
  assign rem_sh  = {rem_q[CB+7:0], quo_q[CB+8]};
  assign rem_sub = rem_sh - den;
  assign num_w   = (CB+9)'(mean_ch) * (CB+9)'(cnt_q) + (CB+9)'(px_ch);

  // a zero count is seen by the scan as unused
  logic cand;
  assign cand = scan_vld_q && (c_rd != '0) &&
                ((k_q == '0) || (c_rd < prev_cnt_q) ||
                 ((c_rd == prev_cnt_q) && (scan_idx_q > prev_idx_q)));

  always_comb begin
    addr = bin_q;
    m_we = 1'b0; c_we = 1'b0; r_we = 1'b0;
    m_wd = mean_q;
    c_wd = (cnt_q == CountMax) ? cnt_q : cnt_q + CB'(1);
    r_addr = k_q[RB-1:0];
    r_wd = {best_idx_q, best_cnt_q};
    unique case (state_q)
      S_CLEAR: begin
        addr = scan_q[IB-1:0]; m_we = 1'b1; c_we = 1'b1;
        m_wd = '0; c_wd = '0;
      end
      S_WR:    begin m_we = 1'b1; c_we = 1'b1; end
      S_SCAN:  addr = scan_q[IB-1:0];
      S_PICK:  r_we = 1'b1;
      S_ORD:   r_addr = k_q[RB-1:0];
      // keep the bin address while the color waits so the means stay put
      S_ORDW, S_EMIT: addr = r_rd[hpe_pkg::RankBits-1:CB];
      default: ;
    endcase
  end

  assign stall_o = (state_q != S_IDLE);
  assign valid_o = out_vld_q;
  assign color_o = out_q;

  logic load_out;
  assign load_out = (state_q == S_EMIT) && (!out_vld_q || !stall_i);

  logic [NB-1:0] lim_w;
  assign lim_w = (pal_q > hpe_pkg::PaletteBits'(hpe_pkg::MaxPalette)) ?
                 NB'(hpe_pkg::MaxPalette) : NB'(pal_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      scan_q     <= '0;
      pal_q      <= hpe_pkg::PaletteReset;
      out_vld_q  <= 1'b0;
      scan_vld_q <= 1'b0;
      k_q        <= '0;
      n_q        <= '0;
      lim_q      <= '0;
      ch_q       <= '0;
      step_q     <= '0;
      best_fnd_q <= 1'b0;
    end else begin
      if (psel && penable && pwrite &&
          paddr[hpe_pkg::AddrBits+1:2] == hpe_pkg::RegPaletteCount) begin
        pal_q <= pwdata[hpe_pkg::PaletteBits-1:0];
      end
      if (load_out) begin
        out_vld_q <= 1'b1;
      end else if (out_vld_q && !stall_i) begin
        out_vld_q <= 1'b0;
      end
      unique case (state_q)
        S_CLEAR: begin
          if (scan_q[IB-1:0] == IB'(hpe_pkg::NumBins - 1)) begin
            scan_q  <= '0;
            state_q <= S_IDLE;
          end else begin
            scan_q <= scan_q + 1'b1;
          end
        end
        S_IDLE: begin
          if (valid_i) begin
            px_q  <= pixel_i;
            bin_q <= {hpe_pkg::chan_bin(pixel_i.pixel_red),
                      hpe_pkg::chan_bin(pixel_i.pixel_green),
                      hpe_pkg::chan_bin(pixel_i.pixel_blue)};
            state_q <= S_RD;
          end
        end
        S_RD: begin
          state_q <= S_DIV;
          ch_q    <= '0;
          step_q  <= '0;
        end
        S_DIV: begin
          if (step_q == 4'd0) begin
            mean_q <= m_rd;
            cnt_q  <= c_rd;
            step_q <= 4'd15; // latch cycle
          end else if (step_q == 4'd15) begin
            // the quotient fits in 8 bits: the top of the numerator starts
            // as the remainder and its low byte is shifted in
            rem_q  <= {8'd0, num_w[CB+8:8]};
            quo_q  <= {num_w[7:0], (CB+1)'(0)};
            step_q <= 4'd1;
          end else begin
            if (rem_sub[CB+8] == 1'b0) begin
              rem_q <= rem_sub;
              quo_q <= {quo_q[CB+7:0], 1'b1};
            end else begin
              rem_q <= rem_sh;
              quo_q <= {quo_q[CB+7:0], 1'b0};
            end
            if (step_q == 4'd9) begin
              step_q <= 4'd15;
              unique case (ch_q)
                2'd0:    mean_q[23:16] <= 8'(quo_q);
                2'd1:    mean_q[15:8]  <= 8'(quo_q);
                default: mean_q[7:0]   <= 8'(quo_q);
              endcase
              ch_q <= ch_q + 2'd1;
              if (ch_q == 2'd2) state_q <= S_WR;
            end else begin
              step_q <= step_q + 4'd1;
            end
          end
        end
        S_WR: begin
          if (px_q.last_pixel) begin
            lim_q      <= lim_w;
            k_q        <= '0;
            n_q        <= '0;
            scan_q     <= '0;
            scan_vld_q <= 1'b0;
            best_fnd_q <= 1'b0;
            state_q    <= (lim_w == '0) ? S_CLEAR : S_SCAN;
          end else begin
            state_q <= S_IDLE;
          end
        end
        S_SCAN: begin
          scan_vld_q <= !scan_q[IB];
          scan_idx_q <= scan_q[IB-1:0];
          if (!scan_q[IB]) scan_q <= scan_q + 1'b1;
          if (cand && (!best_fnd_q || c_rd > best_cnt_q)) begin
            best_fnd_q <= 1'b1;
            best_cnt_q <= c_rd;
            best_idx_q <= scan_idx_q;
          end
          if (scan_q[IB] && !scan_vld_q) state_q <= S_PICK;
        end
        S_PICK: begin
          scan_q <= '0;
          scan_vld_q <= 1'b0;
          best_fnd_q <= 1'b0;
          if (best_fnd_q) begin
            prev_cnt_q <= best_cnt_q;
            prev_idx_q <= best_idx_q;
            n_q <= n_q + 1'b1;
          end
          if (!best_fnd_q || k_q + 1'b1 == lim_q) begin
            state_q <= (best_fnd_q || n_q != '0) ? S_ORD : S_CLEAR;
            k_q     <= '0;
          end else begin
            state_q <= S_SCAN;
            k_q     <= k_q + 1'b1;
          end
        end
        S_ORD: state_q <= S_ORDW;   // rank entry read
        S_ORDW: state_q <= S_EMIT;  // bin means read
        S_EMIT: begin
          if (load_out) begin
            out_q.color_red   <= m_rd[23:16];
            out_q.color_green <= m_rd[15:8];
            out_q.color_blue  <= m_rd[7:0];
            out_q.last_color  <= (k_q + 1'b1 == n_q);
            k_q               <= k_q + 1'b1;
            state_q           <= (k_q + 1'b1 == n_q) ? S_OUT : S_ORD;
          end
        end
        S_OUT: begin
          scan_q  <= '0;
          state_q <= S_CLEAR;
        end
        default: state_q <= S_CLEAR;
      endcase
    end
  end

  `ASSERT_ALWAYS(a_out_only_palette, clk_i, rst_ni,
    !(valid_i && !stall_o) || state_q == S_IDLE, "pixel taken outside idle")
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, valid_o && stall_i,
    valid_o && $stable(color_o), "stalled color changed")
  `ASSERT_ALWAYS(a_emit_bound, clk_i, rst_ni,
    !(state_q == S_EMIT) || (n_q != '0 && k_q < n_q), "emit past palette end")

endmodule
